// File: src/plics_pkg.sv
// ============================================================================
// plics_pkg
// Shared constants and types for the piecewise-linear inverse-CDF sampler.
// ============================================================================
package plics_pkg;

    // Table geometry
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;

    // Field and table widths
    localparam int E_W     = 32;
    localparam int SLOPE_W = 48;
    localparam int CUM_W   = 64;

    // Shared divider geometry
    localparam int DIV_W = 64;
    localparam int DVS_W = 33;

    // Square root geometry
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Slope saturation limits
    localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } plics_stat_t;

endpackage

// File: src/plics_if.sv
// ============================================================================
// plics_if
// Valid/ready channel interfaces for input items and result items.
// ============================================================================
interface plics_item_if import plics_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [IDX_W-1:0] point_index;
    logic [E_W-1:0]   point_energy;
    logic [E_W-1:0]   point_weight;
    logic [E_W-1:0]   uniform_fraction;

    modport source (output valid, op, point_index, point_energy, point_weight,
                    uniform_fraction, input ready);
    modport sink (input valid, op, point_index, point_energy, point_weight,
                  uniform_fraction, output ready);
endinterface

interface plics_result_if import plics_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [E_W-1:0] sampled_energy;
    logic           table_invalid;

    modport source (output valid, sampled_energy, table_invalid, input ready);
    modport sink (input valid, sampled_energy, table_invalid, output ready);
endinterface

// File: src/plics_ram.sv
// ============================================================================
// plics_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module plics_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/plics_div.sv
// ============================================================================
// plics_div
// Restoring divider, one quotient bit per cycle, shared by slope and offset.
// ============================================================================
module plics_div import plics_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output plics_stat_t       stat,
    output logic [DIV_W-1:0]  quotient,
    output logic [DVS_W-1:0]  remainder
);

    localparam int CW = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;
    logic [DVS_W:0]    diff;

    // One restoring step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, dvs_reg};
        diff   = rem_sh - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");
`endif

endmodule

// File: src/plics_sqrt.sv
// ============================================================================
// plics_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ============================================================================
module plics_sqrt import plics_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output plics_stat_t       stat,
    output logic [ROOT_W-1:0] root
);

    localparam int CW  = $clog2(ROOT_W);
    localparam int RMW = ROOT_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [RAD_W-1:0]  v_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RMW-1:0]    rem_reg;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic              ge;
    logic [RMW+1:0]    diff;

    // One root digit
    always_comb
    begin
        rem_sh = {rem_reg, v_reg[RAD_W-1 -: 2]};
        trial  = {{(RMW+2-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        ge     = rem_sh >= trial;
        diff   = rem_sh - trial;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rem_reg  <= ge ? diff[RMW-1:0] : rem_sh[RMW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("square root restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("square root done while busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("square root done without a run");
`endif

endmodule

// File: src/piecewise_linear_inverse_cdf_sampler.sv
// Load: at index zero the point and a zero running area are written; on a zero-width
// segment a zero slope is stored with no divide; else the slope comes from the divider.
// Sample: bin search over up to 63 bins, partial-product multiply for a nonzero slope,
// 32-step square root, 64-step divide unless the denominator is zero; none of it on an
// invalid table. One transaction at a time, the next taken once the FSM is back in idle.
// Reset: rst_n clears point_count and all control; table memories are not cleared.
// ============================================================================
// piecewise_linear_inverse_cdf_sampler
// Loads a piecewise-linear spectrum table and draws energies by inverse CDF.
// ============================================================================
module piecewise_linear_inverse_cdf_sampler import plics_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    plics_item_if.sink           item,
    plics_result_if.source       result
);

    typedef enum logic [4:0] {
        ST_IDLE, LD_RD, LD_CALC, LD_AREA, LD_DIV, LD_WR,
        S_TOT, S_Y1, S_Y2, S_SRCH, S_F1, S_F2, S_F3, S_MUL, S_DISC,
        S_SQ, S_DEN, S_DIV, S_DX, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   n_cur;

    // Load operands and temporaries
    logic [IDX_W-1:0]   idx_reg;
    logic [E_W-1:0]     ld_e_reg;
    logic [E_W-1:0]     ld_w_reg;
    logic [E_W-1:0]     de_reg;
    logic [E_W:0]       sum_reg;
    logic [E_W-1:0]     mag_reg;
    logic               dw_neg_reg;
    logic [CUM_W-1:0]   area_reg;
    logic [SLOPE_W-1:0] slope_reg;

    // Sample temporaries
    logic [E_W-1:0]     u_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CUM_W-1:0]   pa_reg;
    logic [CUM_W-1:0]   pb_reg;
    logic [CUM_W-1:0]   y_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [CUM_W-1:0]   cumj_reg;
    logic [E_W-1:0]     e0_reg;
    logic [E_W-1:0]     f0_reg;
    logic [SLOPE_W-1:0] h_reg;
    logic [SLOPE_W-1:0] hm_reg;
    logic [CUM_W-1:0]   d_reg;
    logic [E_W-1:0]     width_reg;
    logic [CUM_W-1:0]   f0sq_reg;
    logic [111:0]       acc_reg;
    logic [1:0]         k_reg;
    logic [DVS_W-1:0]   denom_reg;

    // Output register
    logic               out_valid_reg;
    logic [E_W-1:0]     out_energy_reg;
    logic               out_inv_reg;
    logic [E_W-1:0]     res_reg;
    logic               inv_reg;

    // Memory ports
    logic               e_we, w_we, s_we, c_we;
    logic [IDX_W-1:0]   e_raddr, w_raddr, s_raddr, c_raddr;
    logic [E_W-1:0]     e_rdata, w_rdata;
    logic [SLOPE_W-1:0] s_rdata;
    logic [CUM_W-1:0]   c_rdata, c_wdata;
    logic [IDX_W-1:0]   p_idx;

    // Shared units
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    plics_stat_t        div_stat;
    logic [DIV_W-1:0]   div_q;
    logic [DVS_W-1:0]   div_r;
    logic               sq_start;
    logic [RAD_W-1:0]   sq_rad;
    plics_stat_t        sq_stat;
    logic [ROOT_W-1:0]  sq_root;

    // Combinational helpers
    logic               accept;
    logic               out_free;
    logic [55:0]        pp;
    logic [111:0]       pp_sh;
    logic [CUM_W-1:0]   t_val;
    logic [CUM_W:0]     disc_sum;
    logic [CUM_W-1:0]   disc_val;
    logic [SLOPE_W-1:0] slope_val;
    logic [E_W+1:0]     dx2;
    logic [E_W-1:0]     dx;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign n_cur    = (point_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                            : point_count_reg;
    assign p_idx    = idx_reg - 1'b1;

    // Saturated running area of the loaded point
    function automatic logic [CUM_W-1:0] cum_new();
        logic [CUM_W:0] s;
        s = {1'b0, cumj_reg} + {1'b0, area_reg};
        return s[CUM_W] ? '1 : s[CUM_W-1:0];
    endfunction

    // Memory controls
    always_comb
    begin
        e_we    = (state_reg == LD_RD);
        w_we    = (state_reg == LD_RD);
        s_we    = (state_reg == LD_WR);
        c_we    = ((state_reg == LD_RD) && (idx_reg == '0)) || (state_reg == LD_WR);
        c_wdata = (state_reg == LD_RD) ? '0 : cum_new();
        e_raddr = j_reg;
        w_raddr = j_reg;
        s_raddr = j_reg;
        c_raddr = j_reg;
        case (state_reg)
            LD_RD:
            begin
                e_raddr = p_idx;
                w_raddr = p_idx;
                c_raddr = p_idx;
            end
            S_TOT:   c_raddr = IDX_W'(n_reg - 1'b1);
            S_Y2:    c_raddr = IDX_W'(n_reg - 2'd2);
            S_SRCH:  c_raddr = j_reg - 1'b1;
            S_F2:    e_raddr = j_reg + 1'b1;
            default: ;
        endcase
    end

    // Load arithmetic
    always_comb
    begin
        if (div_q > {{(DIV_W-SLOPE_W){1'b0}}, SLOPE_MAX})
        begin
            slope_val = dw_neg_reg ? SLOPE_MIN : SLOPE_MAX;
        end
        else
        begin
            slope_val = dw_neg_reg ? (SLOPE_W'(0) - div_q[SLOPE_W-1:0])
                                   : div_q[SLOPE_W-1:0];
        end
    end

    // Sample arithmetic: partial product, discriminant, offset
    always_comb
    begin
        pp    = (k_reg[0] ? {8'b0, hm_reg[47:24]} : {8'b0, hm_reg[23:0]})
              * (k_reg[1] ? {24'b0, d_reg[63:32]} : {24'b0, d_reg[31:0]});
        pp_sh = '0;
        case (k_reg)
            2'd0:    pp_sh = {56'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 24'b0};
            2'd2:    pp_sh = {24'b0, pp, 32'b0};
            default: pp_sh = {pp, 56'b0};
        endcase

        t_val    = (|acc_reg[111:79]) ? '1 : acc_reg[78:15];
        disc_sum = {1'b0, f0sq_reg} + {1'b0, t_val};
        if (h_reg == '0)
        begin
            disc_val = f0sq_reg;
        end
        else if (!h_reg[SLOPE_W-1])
        begin
            disc_val = disc_sum[CUM_W] ? '1 : disc_sum[CUM_W-1:0];
        end
        else
        begin
            disc_val = (f0sq_reg > t_val) ? (f0sq_reg - t_val) : '0;
        end

        dx2 = {div_q[E_W:0], 1'b0}
            + {{(E_W+1){1'b0}}, ({div_r, 1'b0} >= {1'b0, denom_reg})};
        if (div_q > {32'b0, width_reg})
        begin
            dx = width_reg;
        end
        else if (dx2 > {2'b0, width_reg})
        begin
            dx = width_reg;
        end
        else
        begin
            dx = dx2[E_W-1:0];
        end
    end

    // Unit starts
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = d_reg;
        div_divisor  = denom_reg;
        sq_start     = (state_reg == S_DISC);
        sq_rad       = disc_val;
        if ((state_reg == LD_AREA) && (de_reg != '0))
        begin
            div_start    = 1'b1;
            div_dividend = {16'b0, mag_reg, 16'b0};
            div_divisor  = {1'b0, de_reg};
        end
        else if ((state_reg == S_DEN) && (denom_reg != '0))
        begin
            div_start = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        state_next = LD_RD;
                    end
                    else if (n_cur < CNT_W'(2))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_TOT;
                    end
                end
            end
            LD_RD:   state_next = (idx_reg == '0) ? ST_IDLE : LD_CALC;
            LD_CALC: state_next = LD_AREA;
            LD_AREA: state_next = (de_reg != '0) ? LD_DIV : LD_WR;
            LD_DIV:  state_next = div_stat.done ? LD_WR : LD_DIV;
            LD_WR:   state_next = ST_IDLE;
            S_TOT:   state_next = S_Y1;
            S_Y1:    state_next = S_Y2;
            S_Y2:    state_next = S_SRCH;
            S_SRCH:
            begin
                if (!((j_reg != '0) && (c_rdata > y_reg)))
                begin
                    state_next = S_F1;
                end
            end
            S_F1:    state_next = S_F2;
            S_F2:    state_next = S_F3;
            S_F3:    state_next = (h_reg == '0) ? S_DISC : S_MUL;
            S_MUL:   state_next = (k_reg == 2'd3) ? S_DISC : S_MUL;
            S_DISC:  state_next = S_SQ;
            S_SQ:    state_next = sq_stat.done ? S_DEN : S_SQ;
            S_DEN:   state_next = (denom_reg == '0) ? S_FIN : S_DIV;
            S_DIV:   state_next = div_stat.done ? S_DX : S_DIV;
            S_DX:    state_next = S_FIN;
            S_FIN:   state_next = out_free ? ST_IDLE : S_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    // State, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                point_count_reg <= cfg_wdata;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg  <= item.point_index;
                ld_e_reg <= item.point_energy;
                ld_w_reg <= item.point_weight;
                u_reg    <= item.uniform_fraction;
                n_reg    <= n_cur;
                res_reg  <= '0;
                inv_reg  <= (n_cur < CNT_W'(2));
            end
            LD_CALC:
            begin
                cumj_reg   <= c_rdata;
                de_reg     <= (ld_e_reg > e_rdata) ? (ld_e_reg - e_rdata) : '0;
                sum_reg    <= {1'b0, w_rdata} + {1'b0, ld_w_reg};
                dw_neg_reg <= ld_w_reg < w_rdata;
                mag_reg    <= (ld_w_reg < w_rdata) ? (w_rdata - ld_w_reg)
                                                   : (ld_w_reg - w_rdata);
            end
            LD_AREA:
            begin
                area_reg  <= ({32'b0, sum_reg[E_W:1]} * {32'b0, de_reg})
                           + (sum_reg[0] ? {33'b0, de_reg[E_W-1:1]} : '0);
                slope_reg <= '0;
            end
            LD_DIV:
            begin
                if (div_stat.done)
                begin
                    slope_reg <= slope_val;
                end
            end
            S_Y1:
            begin
                pa_reg <= {32'b0, u_reg} * {32'b0, c_rdata[63:32]};
                pb_reg <= {32'b0, u_reg} * {32'b0, c_rdata[31:0]};
            end
            S_Y2:
            begin
                y_reg <= pa_reg + {32'b0, pb_reg[63:32]};
                j_reg <= IDX_W'(n_reg - 2'd2);
            end
            S_SRCH:
            begin
                if ((j_reg != '0) && (c_rdata > y_reg))
                begin
                    j_reg <= j_reg - 1'b1;
                end
                else
                begin
                    cumj_reg <= c_rdata;
                end
            end
            S_F2:
            begin
                e0_reg <= e_rdata;
                f0_reg <= w_rdata;
                h_reg  <= s_rdata;
                hm_reg <= s_rdata[SLOPE_W-1] ? (SLOPE_W'(0) - s_rdata) : s_rdata;
                d_reg  <= (y_reg >= cumj_reg) ? (y_reg - cumj_reg) : '0;
            end
            S_F3:
            begin
                width_reg <= (e_rdata > e0_reg) ? (e_rdata - e0_reg) : '0;
                f0sq_reg  <= {32'b0, f0_reg} * {32'b0, f0_reg};
                acc_reg   <= '0;
                k_reg     <= '0;
            end
            S_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                k_reg   <= k_reg + 1'b1;
            end
            S_SQ:
            begin
                denom_reg <= {1'b0, f0_reg} + {1'b0, sq_root};
                res_reg   <= e0_reg;
            end
            S_DX:
            begin
                res_reg <= e0_reg + dx;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_energy_reg <= res_reg;
                    out_inv_reg    <= inv_reg;
                end
            end
            default: ;
        endcase
    end

    // Table memories
    plics_ram #(.WIDTH(E_W), .DEPTH(MAX_POINTS)) u_energy (
        .clk(clk), .we(e_we), .waddr(idx_reg), .wdata(ld_e_reg),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    plics_ram #(.WIDTH(E_W), .DEPTH(MAX_POINTS)) u_weight (
        .clk(clk), .we(w_we), .waddr(idx_reg), .wdata(ld_w_reg),
        .raddr(w_raddr), .rdata(w_rdata)
    );
    plics_ram #(.WIDTH(SLOPE_W), .DEPTH(MAX_POINTS)) u_slope (
        .clk(clk), .we(s_we), .waddr(p_idx), .wdata(slope_reg),
        .raddr(s_raddr), .rdata(s_rdata)
    );
    plics_ram #(.WIDTH(CUM_W), .DEPTH(MAX_POINTS)) u_cum (
        .clk(clk), .we(c_we), .waddr(idx_reg), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // Shared iterative units
    plics_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .stat(div_stat), .quotient(div_q), .remainder(div_r)
    );
    plics_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
        .stat(sq_stat), .root(sq_root)
    );

    // Channel outputs
    assign item.ready            = (state_reg == ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.sampled_energy = out_energy_reg;
    assign result.table_invalid  = out_inv_reg;

`ifndef SYNTHESIS
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.table_invalid |-> result.sampled_energy == '0)
        else $error("invalid table result carries nonzero energy");
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.op == OP_LOAD) |=> !$rose(out_valid_reg))
        else $error("load produced a result");
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && sq_stat.busy))
        else $error("divider and square root overlap");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the piecewise-linear inverse-CDF sampler. A short
// stimulus table runs first, then random load and sample traffic over several
// point counts, with random idling on both channels. Each result is checked
// against the row's expected value or an in-bench model of the table arithmetic.
// ============================================================================
module tb;
    import plics_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic       op;
        logic [5:0] idx;
        logic [31:0] energy;
        logic [31:0] weight;
        logic [31:0] frac;
        logic       has_exp;
        logic [31:0] exp_energy;
        logic       exp_invalid;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] energy;
        logic        invalid;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    plics_item_if   item_ch ();
    plics_result_if res_ch ();

    piecewise_linear_inverse_cdf_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Model state
    logic [31:0] energy_mem [MAX_POINTS];
    logic [31:0] weight_mem [MAX_POINTS];
    longint      slope_mem  [MAX_POINTS];
    logic [63:0] area_mem   [MAX_POINTS];
    logic [6:0]  points_in_use;

    draw_t draws_pending [$];
    int    err_count;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    quiet_cycles;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Store one point and update the segment slope and running area
    function automatic void store_point(logic [5:0] idx, logic [31:0] e, logic [31:0] w);
        int unsigned p;
        logic [31:0] de;
        longint      dw;
        logic [63:0] mag;
        logic [63:0] wsum;
        logic [63:0] area;
        energy_mem[idx] = e;
        weight_mem[idx] = w;
        if (idx == 0)
        begin
            area_mem[0] = 0;
            return;
        end
        p  = idx - 1;
        de = (e > energy_mem[p]) ? e - energy_mem[p] : 32'd0;
        if (de == 0)
            slope_mem[p] = 0;
        else
        begin
            dw  = longint'({32'd0, w}) - longint'({32'd0, weight_mem[p]});
            mag = (dw < 0) ? -dw : dw;
            mag = (mag << 16) / {32'd0, de};
            if (mag > 64'h7FFF_FFFF_FFFF)
                slope_mem[p] = (dw < 0) ? -longint'(64'h8000_0000_0000) : 64'h7FFF_FFFF_FFFF;
            else
                slope_mem[p] = (dw < 0) ? -longint'(mag) : longint'(mag);
        end
        wsum = {32'd0, weight_mem[p]} + {32'd0, w};
        area = (wsum >> 1) * {32'd0, de};
        if (wsum[0])
            area = sat_sum(area, {33'd0, de[31:1]});
        area_mem[idx] = sat_sum(area_mem[p], area);
    endfunction

    // Invert the cumulative area for one uniform fraction
    function automatic draw_t draw_energy(logic [31:0] u);
        draw_t       r;
        int          n;
        int          j;
        logic [31:0] e0;
        logic [31:0] width;
        logic [63:0] f0;
        logic [63:0] total;
        logic [63:0] y;
        logic [63:0] d;
        logic [63:0] f0sq;
        logic [63:0] disc;
        logic [63:0] t;
        logic [63:0] habs;
        logic [127:0] prod;
        logic [63:0] denom;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] dx;
        longint      h;
        n = (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;
        if (n < 2)
        begin
            r.energy  = 0;
            r.invalid = 1'b1;
            return r;
        end
        total = area_mem[n-1];
        y = {32'd0, u} * {32'd0, total[63:32]} + (({32'd0, u} * {32'd0, total[31:0]}) >> 32);
        j = n - 2;
        while (j > 0 && area_mem[j] > y)
            j--;
        e0    = energy_mem[j];
        width = (energy_mem[j+1] > e0) ? energy_mem[j+1] - e0 : 32'd0;
        f0    = {32'd0, weight_mem[j]};
        h     = slope_mem[j];
        d     = (y >= area_mem[j]) ? y - area_mem[j] : 64'd0;
        f0sq  = f0 * f0;
        if (h == 0)
            disc = f0sq;
        else
        begin
            habs = (h < 0) ? -h : h;
            prod = {64'd0, habs} * {64'd0, d};
            t    = (prod[127:79] != 0) ? '1 : prod[78:15];
            if (h > 0)
                disc = sat_sum(f0sq, t);
            else
                disc = (f0sq > t) ? f0sq - t : 64'd0;
        end
        denom = f0 + int_sqrt(disc);
        if (denom == 0)
            dx = 0;
        else
        begin
            q   = d / denom;
            rem = d % denom;
            if (q > width)
                dx = width;
            else
            begin
                dx = 2 * q + (((rem << 1) >= denom) ? 64'd1 : 64'd0);
                if (dx > width)
                    dx = width;
            end
        end
        r.energy  = e0 + dx[31:0];
        r.invalid = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
        err_count++;
    endtask

    // Result side: random stall and compare against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        draw_t exp_d;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (draws_pending.size() == 0)
                report("unexpected transaction", 0, res_ch.sampled_energy);
            else
            begin
                exp_d = draws_pending.pop_front();
                if (res_ch.sampled_energy !== exp_d.energy)
                    report("sampled_energy", exp_d.energy, res_ch.sampled_energy);
                if (res_ch.table_invalid !== exp_d.invalid)
                    report("table_invalid", 32'(exp_d.invalid), 32'(res_ch.table_invalid));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive one item, with a random gap before it, and wait for acceptance
    task automatic send_item(logic op, logic [5:0] idx, logic [31:0] e, logic [31:0] w,
                             logic [31:0] u, logic has_exp, draw_t exp_d);
        int    gap;
        draw_t want;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 8)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.op               <= op;
        item_ch.point_index      <= idx;
        item_ch.point_energy     <= e;
        item_ch.point_weight     <= w;
        item_ch.uniform_fraction <= u;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (op == OP_LOAD)
            store_point(idx, e, w);
        else
        begin
            want = has_exp ? exp_d : draw_energy(u);
            draws_pending = {draws_pending, want};
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (draws_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_points(logic [6:0] n);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        points_in_use = n;
    endtask

    stim_row_t rows [$];

    // Append one stimulus row
    function automatic void add_row(row_kind_t k, logic op, int idx, logic [31:0] e,
                                    logic [31:0] w, logic [31:0] u, int he,
                                    logic [31:0] xe, int xi);
        stim_row_t r;
        r = '{k, op, 6'(idx), e, w, u, 1'(he), xe, 1'(xi)};
        rows = {rows, r};
    endfunction

    initial
    begin
        draw_t       xd;
        logic [31:0] e;
        logic [31:0] w;
        logic [5:0]  idx;
        logic [6:0]  cnt;
        int          phase;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_LOAD;
        item_ch.point_index = '0;
        item_ch.point_energy = '0;
        item_ch.point_weight = '0;
        item_ch.uniform_fraction = '0;
        points_in_use = 0;
        send_idle_pct = 21;
        recv_idle_pct = 45;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: invalid tables, flat zero segment, slopes both ways,
        // non-ascending energies, field extremes
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h0, 1, 0, 1);
        add_row(ROW_CFG, OP_LOAD, 1, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 1);
        add_row(ROW_ITEM, OP_LOAD, 0, 32'h0, 32'h0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 1, 32'h1_0000, 32'h0, 0, 0, 0, 0);
        add_row(ROW_CFG, OP_LOAD, 2, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 1, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 2, 32'h2_0000, 32'h1_0000, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 3, 32'h1_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 4, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_LOAD, 6, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0);
        add_row(ROW_CFG, OP_LOAD, 7, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h4000_0000, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'hC000_0001, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, OP_SAMPLE, 0, 0, 0, 32'h1234_5678, 1, 0, 1);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                set_points({1'b0, rows[i].idx});
            else
            begin
                xd.energy  = rows[i].exp_energy;
                xd.invalid = rows[i].exp_invalid;
                send_item(rows[i].op, rows[i].idx, rows[i].energy, rows[i].weight,
                          rows[i].frac, rows[i].has_exp, xd);
            end
        end

        // Fill the whole table in ascending energy order
        e = $urandom_range(32'hFFFF);
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            w = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h100_0000);
            send_item(OP_LOAD, 6'(i), e, w, $urandom, 1'b0, xd);
            e = e + $urandom_range(32'h1FF_FFFF, 1);
        end

        // Random phases over point counts; idling mode changes every four phases
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0: cnt = 7'(MAX_POINTS);
                1: cnt = 7'd2;
                2: cnt = (phase < 6) ? 7'd0 : 7'd1;
                default: cnt = 7'($urandom_range(MAX_POINTS, 2));
            endcase
            set_points(cnt);
            send_idle_pct = (phase < 4) ? 21 : (phase < 8) ? 45 : 0;
            recv_idle_pct = (phase < 4) ? 45 : (phase < 8) ? 21 : 0;
            for (int k = 0; k < 95; k++)
            begin
                if (phase == 5 && k == 40)
                begin
                    item_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (draws_pending.size() != 0);
                end
                if ($urandom_range(99) < 25)
                begin
                    // Reload a point, mostly near its old energy, sometimes anywhere
                    idx = 6'($urandom_range(MAX_POINTS - 1));
                    if ($urandom_range(4) == 0)
                        e = $urandom;
                    else
                        e = energy_mem[idx] + $urandom_range(32'hFFFF) - 32'h8000;
                    w = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h100_0000);
                    send_item(OP_LOAD, idx, e, w, $urandom, 1'b0, xd);
                end
                else
                    send_item(OP_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, 1'b0, xd);
            end
        end

        wait_drained();
        if (err_count == 0 && draws_pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
